/* design/mnop_pkg.sv */
package mnop_pkg;

   // Table size and time arithmetic width.
   localparam int OPEN_NOTES = 64;
   localparam int TIME_BITS  = 32;

   // Fixed field widths of the event and result items.
   localparam int EVT_TIME_W = 32;
   localparam int MODE_W     = 1;
   localparam int TRACK_W    = 7;
   localparam int CHAN_W     = 4;
   localparam int PITCH_W    = 7;
   localparam int INSTR_W    = 7;
   localparam int VEL_W      = 7;
   localparam int STATUS_W   = 3;
   localparam int COUNT_W    = 7;
   localparam int KEY_W      = MODE_W + TRACK_W + CHAN_W + PITCH_W + INSTR_W;

   // Internal fill count, wide enough to hold OPEN_NOTES itself.
   localparam int CNT_BITS = $clog2(OPEN_NOTES + 1);

   // Packed stream widths, rounded up to whole bytes.
   localparam int REQ_BITS  = EVT_TIME_W + KEY_W + VEL_W;
   localparam int REQ_W     = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS  = STATUS_W + 2 * EVT_TIME_W + VEL_W + KEY_W + COUNT_W;
   localparam int RSP_W     = ((RSP_BITS + 7) / 8) * 8;

   typedef logic [TIME_BITS-1:0] time_type;
   typedef logic [KEY_W-1:0]     key_type;
   typedef logic [CNT_BITS-1:0]  count_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_STORED    = 3'd0,
      ST_PAIR_OK   = 3'd1,
      ST_PAIR_BAD  = 3'd2,
      ST_UNMATCHED = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

   // One open note held in a table cell.
   typedef struct packed {
      key_type              key;
      time_type             start;
      logic [VEL_W-1:0]     velocity;
   } entry_type;

   // Per-cell controls driven by the sequencer.
   typedef struct packed {
      logic cmp_en;
      logic cell_valid;
      logic load_en;
      logic shift_en;
   } cell_ctrl_type;

endpackage

/* design/mnop_cell.sv */
module mnop_cell (
   input  logic                      clock,
   input  mnop_pkg::cell_ctrl_type   ctrl,
   input  mnop_pkg::key_type         cmp_key,
   input  mnop_pkg::entry_type       load_entry,
   input  mnop_pkg::entry_type       next_entry,
   output mnop_pkg::entry_type       entry_out,
   output logic                      hit_out
);

   mnop_pkg::entry_type entry_ff;
   mnop_pkg::entry_type entry_in;
   logic                hit_ff;
   logic                hit_in;

   // A new note lands here, or the younger neighbor moves down one slot.
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.load_en) begin
         entry_in = load_entry;
      end else if (ctrl.shift_en) begin
         entry_in = next_entry;
      end
      hit_in = hit_ff;
      if (ctrl.cmp_en) begin
         hit_in = ctrl.cell_valid && (entry_ff.key == cmp_key);
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      hit_ff   <= hit_in;
   end

   assign entry_out = entry_ff;
   assign hit_out   = hit_ff;

endmodule

/* design/midi_note_on_off_pairing_unit.sv */
// MIDI note-on / note-off pairing unit.
// Note events arrive on the req_ stream, one item per event. An event with a
// nonzero velocity opens a note, if a cell is free, in a row of OPEN_NOTES
// cells kept in age order, oldest in cell 0. An event with zero velocity closes
// the oldest open note with the same key (time mode, track, channel, pitch,
// instrument); the cells above it move down one place and the pair is reported.
// Every event yields exactly one result item on the rsp_ stream, carrying a
// status code, the pair's start, duration and velocity, the key fields and
// the number of open notes after the event.
// Timing: an item is taken while the cells compare their keys; the select
// step then picks the oldest hit and the commit step updates the row and
// loads the output register, which drives rsp_tvalid. A new item is taken
// only after the commit step, so the unit is through with one event before
// it takes the next; the sequencer steps are compare, select and commit.
// The output register lets a new item be taken while a result still waits.
// If the receiver stalls, the commit step holds until the waiting result is
// taken, and the row is not changed until then.
// Reset empties the table at once (the fill count is cleared) and drops any
// result not yet taken.
module midi_note_on_off_pairing_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // event_time[31:0], time_mode[32], track_num[39:33], channel_num[43:40],
   // pitch_num[50:44], instrument_num[57:51], note_velocity[64:58]
   input  logic [mnop_pkg::REQ_W-1:0]    req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // status[2:0], pair_start[34:3], pair_duration[66:35], pair_velocity[73:67],
   // pair_track[80:74], pair_channel[84:81], pair_pitch[91:85],
   // pair_instrument[98:92], pair_time_mode[99], open_count[106:100]
   output logic [mnop_pkg::RSP_W-1:0]    rsp_tdata
);

   localparam int N = mnop_pkg::OPEN_NOTES;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SELECT,
      S_COMMIT
   } state_type;

   // Unpacked event fields.
   mnop_pkg::key_type                  req_key;
   mnop_pkg::time_type                 req_time;
   logic [mnop_pkg::VEL_W-1:0]         req_vel;

   assign req_time = mnop_pkg::time_type'(req_tdata[31:0]);
   assign req_key  = {req_tdata[32], req_tdata[39:33], req_tdata[43:40],
                      req_tdata[50:44], req_tdata[57:51]};
   assign req_vel  = req_tdata[64:58];

   state_type                          state_ff, state_in;
   mnop_pkg::key_type                  key_ff, key_in;
   mnop_pkg::time_type                 time_ff, time_in;
   logic [mnop_pkg::VEL_W-1:0]         vel_ff, vel_in;
   mnop_pkg::count_type                count_ff, count_in;
   logic                               found_ff, found_in;
   logic [N-1:0]                       shift_ff, shift_in;
   mnop_pkg::entry_type                sel_ff, sel_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   mnop_pkg::status_type               status_ff, status_in;
   logic [31:0]                        start_ff, start_in;
   logic [31:0]                        dur_ff, dur_in;
   logic [mnop_pkg::VEL_W-1:0]         pvel_ff, pvel_in;
   mnop_pkg::key_type                  rkey_ff, rkey_in;
   logic [mnop_pkg::COUNT_W-1:0]       ocount_ff, ocount_in;

   // Cell row signals.
   mnop_pkg::cell_ctrl_type            ctrl_w [N];
   mnop_pkg::entry_type                entry_w [N];
   mnop_pkg::entry_type                load_entry;
   logic [N-1:0]                       hit_w;
   logic [N-1:0]                       low_mask;
   logic [N-1:0]                       first_hit;

   logic                               accept;
   logic                               commit;
   logic                               is_on;
   logic                               full;
   logic                               do_shift;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   // Commit only when the output register is free or being emptied now.
   assign commit     = (state_ff == S_COMMIT) && (!rsp_valid_ff || rsp_tready);
   assign is_on      = (vel_ff != '0);
   assign full       = (count_ff >= mnop_pkg::count_type'(N));
   assign do_shift   = commit && !is_on && found_ff;

   assign load_entry = '{key: key_ff, start: time_ff, velocity: vel_ff};

   // Lowest set hit is the oldest match; low_mask covers it and all below.
   assign low_mask  = hit_w ^ (hit_w - {{(N-1){1'b0}}, 1'b1});
   assign first_hit = hit_w & low_mask;

   genvar gi;
   generate
      for (gi = 0; gi < N; gi++) begin : g_cell
         mnop_pkg::entry_type next_e;
         if (gi == N - 1) begin : g_top
            assign next_e = entry_w[gi];
         end else begin : g_mid
            assign next_e = entry_w[gi+1];
         end

         assign ctrl_w[gi].cmp_en     = accept;
         assign ctrl_w[gi].cell_valid = (mnop_pkg::count_type'(gi) < count_ff);
         assign ctrl_w[gi].load_en    = commit && is_on && !full &&
                                        (count_ff == mnop_pkg::count_type'(gi));
         assign ctrl_w[gi].shift_en   = do_shift && shift_ff[gi];

         mnop_cell u_cell (
            .clock      (clock),
            .ctrl       (ctrl_w[gi]),
            .cmp_key    (req_key),
            .load_entry (load_entry),
            .next_entry (next_e),
            .entry_out  (entry_w[gi]),
            .hit_out    (hit_w[gi])
         );
      end
   endgenerate

   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      time_in      = time_ff;
      vel_in       = vel_ff;
      count_in     = count_ff;
      found_in     = found_ff;
      shift_in     = shift_ff;
      sel_in       = sel_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      status_in    = status_ff;
      start_in     = start_ff;
      dur_in       = dur_ff;
      pvel_in      = pvel_ff;
      rkey_in      = rkey_ff;
      ocount_in    = ocount_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               key_in   = req_key;
               time_in  = req_time;
               vel_in   = req_vel;
               state_in = S_SELECT;
            end
         end
         S_SELECT: begin
            // Pick the oldest matching note and mark the cells that move.
            sel_in = '0;
            for (int i = 0; i < N; i++) begin
               if (first_hit[i]) begin
                  sel_in = mnop_pkg::entry_type'(sel_in | entry_w[i]);
               end
            end
            found_in = |hit_w;
            shift_in = ~(low_mask & ~first_hit);
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (commit) begin
               rsp_valid_in = 1'b1;
               rkey_in      = key_ff;
               start_in     = '0;
               dur_in       = '0;
               pvel_in      = '0;
               if (is_on) begin
                  if (full) begin
                     status_in = mnop_pkg::ST_FULL;
                  end else begin
                     status_in = mnop_pkg::ST_STORED;
                     count_in  = count_ff + mnop_pkg::count_type'(1);
                  end
               end else if (!found_ff) begin
                  status_in = mnop_pkg::ST_UNMATCHED;
               end else begin
                  start_in = 32'(sel_ff.start);
                  pvel_in  = sel_ff.velocity;
                  count_in = count_ff - mnop_pkg::count_type'(1);
                  if (time_ff > sel_ff.start) begin
                     status_in = mnop_pkg::ST_PAIR_OK;
                     dur_in    = 32'(time_ff - sel_ff.start);
                  end else begin
                     status_in = mnop_pkg::ST_PAIR_BAD;
                  end
               end
               ocount_in = mnop_pkg::COUNT_W'(count_in);
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff    <= key_in;
      time_ff   <= time_in;
      vel_ff    <= vel_in;
      found_ff  <= found_in;
      shift_ff  <= shift_in;
      sel_ff    <= sel_in;
      status_ff <= status_in;
      start_ff  <= start_in;
      dur_ff    <= dur_in;
      pvel_ff   <= pvel_in;
      rkey_ff   <= rkey_in;
      ocount_ff <= ocount_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = mnop_pkg::RSP_W'({ocount_ff, rkey_ff[25],
                                         rkey_ff[6:0], rkey_ff[13:7],
                                         rkey_ff[17:14], rkey_ff[24:18],
                                         pvel_ff, dur_ff, start_ff,
                                         status_ff});

endmodule

/* design/mnop_checker.sv */
module mnop_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [mnop_pkg::RSP_W-1:0]    rsp_tdata
);

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result item changed while stalled");

   // An event is worked on alone: no second item right after acceptance.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while an event is in work");

   // The open-note count never exceeds the table size.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[106:100] <= 7'(mnop_pkg::OPEN_NOTES))
      else $error("open note count out of range");

   // Results without a pair carry no start, duration or velocity.
   a_no_pair_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[2:0] == mnop_pkg::ST_STORED ||
                     rsp_tdata[2:0] == mnop_pkg::ST_UNMATCHED ||
                     rsp_tdata[2:0] == mnop_pkg::ST_FULL)
      |-> rsp_tdata[73:3] == '0)
      else $error("pair fields set without a pair");

   // A pair with bad timing has zero duration; a good one a nonzero one.
   a_duration: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[2:0] == mnop_pkg::ST_PAIR_BAD ||
                     rsp_tdata[2:0] == mnop_pkg::ST_PAIR_OK)
      |-> ((rsp_tdata[66:35] == '0) == (rsp_tdata[2:0] == mnop_pkg::ST_PAIR_BAD)))
      else $error("duration does not agree with status");

endmodule

bind midi_note_on_off_pairing_unit mnop_checker u_mnop_checker (.*);

/* tb/note_pair_checker.sv */
`timescale 1ns / 100ps

// Watches both streams of the note pairing unit. It keeps its own copy of the
// open-note table, works out the result for every event taken in, and checks
// the results that come out against them in order.
module note_pair_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   input  logic                       req_tready,
   input  logic [mnop_pkg::REQ_W-1:0] req_tdata,
   input  logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic [mnop_pkg::RSP_W-1:0] rsp_tdata,
   output int                         fail_count,
   output int                         pending
);

   // Event item, first packed member in the highest bits.
   typedef struct packed {
      logic [mnop_pkg::VEL_W-1:0]      vel;
      logic [mnop_pkg::INSTR_W-1:0]    instr;
      logic [mnop_pkg::PITCH_W-1:0]    pitch;
      logic [mnop_pkg::CHAN_W-1:0]     chan;
      logic [mnop_pkg::TRACK_W-1:0]    track;
      logic [mnop_pkg::MODE_W-1:0]     mode;
      logic [mnop_pkg::EVT_TIME_W-1:0] tick_time;
   } note_event_type;

   typedef struct packed {
      logic [mnop_pkg::COUNT_W-1:0]    open_cnt;
      logic [mnop_pkg::MODE_W-1:0]     mode;
      logic [mnop_pkg::INSTR_W-1:0]    instr;
      logic [mnop_pkg::PITCH_W-1:0]    pitch;
      logic [mnop_pkg::CHAN_W-1:0]     chan;
      logic [mnop_pkg::TRACK_W-1:0]    track;
      logic [mnop_pkg::VEL_W-1:0]      vel;
      logic [mnop_pkg::EVT_TIME_W-1:0] duration;
      logic [mnop_pkg::EVT_TIME_W-1:0] start;
      mnop_pkg::status_type            status;
   } note_result_type;

   // Open notes in age order, oldest at index 0.
   mnop_pkg::key_type          open_key   [mnop_pkg::OPEN_NOTES];
   mnop_pkg::time_type         open_start [mnop_pkg::OPEN_NOTES];
   logic [mnop_pkg::VEL_W-1:0] open_vel   [mnop_pkg::OPEN_NOTES];
   int                         open_total;

   note_result_type awaited_q[$];
   int              results_seen;

   task automatic report_mismatch(string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      fail_count++;
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d: %s is %0h, expected %0h",
                                   results_seen, name, got, want));
   endtask

   function automatic note_result_type pair_event(note_event_type ev);
      mnop_pkg::key_type key;
      note_result_type   r;
      int                hit;
      key = {ev.mode, ev.track, ev.chan, ev.pitch, ev.instr};
      r = '0;
      r.status = mnop_pkg::ST_STORED;
      r.mode   = ev.mode;
      r.track  = ev.track;
      r.chan   = ev.chan;
      r.pitch  = ev.pitch;
      r.instr  = ev.instr;
      if (ev.vel != 0) begin
         if (open_total >= mnop_pkg::OPEN_NOTES) begin
            r.status = mnop_pkg::ST_FULL;
         end else begin
            open_key[open_total]   = key;
            open_start[open_total] = ev.tick_time;
            open_vel[open_total]   = ev.vel;
            open_total++;
         end
      end else begin
         hit = -1;
         for (int i = 0; i < open_total; i++)
            if (hit < 0 && open_key[i] == key)
               hit = i;
         if (hit < 0) begin
            r.status = mnop_pkg::ST_UNMATCHED;
         end else begin
            r.start = open_start[hit];
            r.vel   = open_vel[hit];
            if (ev.tick_time > r.start) begin
               r.status   = mnop_pkg::ST_PAIR_OK;
               r.duration = ev.tick_time - r.start;
            end else begin
               r.status = mnop_pkg::ST_PAIR_BAD;
            end
            for (int i = hit; i + 1 < open_total; i++) begin
               open_key[i]   = open_key[i + 1];
               open_start[i] = open_start[i + 1];
               open_vel[i]   = open_vel[i + 1];
            end
            open_total--;
         end
      end
      r.open_cnt = mnop_pkg::COUNT_W'(open_total);
      return r;
   endfunction

   always @(posedge clock) begin : watch
      note_result_type got;
      note_result_type want;
      if (reset) begin
         awaited_q.delete();
         open_total   = 0;
         results_seen = 0;
         fail_count   = 0;
      end else begin
         // A result never leaves at the edge where its event is taken, so the
         // output side is handled before this edge's input.
         if (rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
            got = rsp_tdata[mnop_pkg::RSP_BITS-1:0];
            if (awaited_q.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with no event waiting",
                                         results_seen));
            end else begin
               want = awaited_q.pop_front();
               check_field("status", 32'(got.status), 32'(want.status));
               check_field("pair_start", got.start, want.start);
               check_field("pair_duration", got.duration, want.duration);
               check_field("pair_velocity", 32'(got.vel), 32'(want.vel));
               check_field("pair_track", 32'(got.track), 32'(want.track));
               check_field("pair_channel", 32'(got.chan), 32'(want.chan));
               check_field("pair_pitch", 32'(got.pitch), 32'(want.pitch));
               check_field("pair_instrument", 32'(got.instr), 32'(want.instr));
               check_field("pair_time_mode", 32'(got.mode), 32'(want.mode));
               check_field("open_count", 32'(got.open_cnt), 32'(want.open_cnt));
            end
            results_seen++;
         end
         if (req_tvalid === 1'b1 && req_tready === 1'b1)
            awaited_q.push_back(pair_event(req_tdata[mnop_pkg::REQ_BITS-1:0]));
      end
      pending = awaited_q.size();
   end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

// Top of the bench for the note pairing unit. This module only produces the
// event stream, paces the result side and gives the verdict; the checker
// beside the unit does all prediction and comparison.
module tb_top;

   // Same layout as the req_tdata comment of the unit: event_time in the
   // lowest bits, velocity in the highest.
   typedef struct packed {
      logic [mnop_pkg::VEL_W-1:0]      vel;
      logic [mnop_pkg::INSTR_W-1:0]    instr;
      logic [mnop_pkg::PITCH_W-1:0]    pitch;
      logic [mnop_pkg::CHAN_W-1:0]     chan;
      logic [mnop_pkg::TRACK_W-1:0]    track;
      logic [mnop_pkg::MODE_W-1:0]     mode;
      logic [mnop_pkg::EVT_TIME_W-1:0] tick_time;
   } note_event_type;

   logic                       clock;
   logic                       reset      = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [mnop_pkg::REQ_W-1:0] req_tdata  = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [mnop_pkg::RSP_W-1:0] rsp_tdata;

   int fail_count;
   int pending;

   // While calm is set, neither side inserts idle cycles.
   bit calm           = 1'b0;
   bit hold_done      = 1'b0;
   int results_taken  = 0;

   midi_note_on_off_pairing_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   note_pair_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard limit. The slowest legal run (every item behind the longest gap on
   // both sides, plus the long receiver hold and the drains between phases)
   // stays well under a quarter of this.
   initial begin
      #20_000_000;
      $display("simulation failed");
      $finish;
   end

   // Idle lengths: mostly none or short, now and then a long one.
   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45)
         return 0;
      else if (r < 85)
         return $urandom_range(1, 3);
      else if (r < 95)
         return $urandom_range(4, 12);
      else
         return $urandom_range(20, 60);
   endfunction

   function automatic note_event_type make_event(mnop_pkg::time_type t,
                                                 mnop_pkg::key_type k,
                                                 logic [mnop_pkg::VEL_W-1:0] v);
      note_event_type ev;
      ev.tick_time = t;
      {ev.mode, ev.track, ev.chan, ev.pitch, ev.instr} = k;
      ev.vel = v;
      return ev;
   endfunction

   // Offers one event after an optional gap and returns at the falling edge
   // after it was taken. tvalid stays high into the next call, so with no gap
   // the next item follows back to back.
   task automatic offer_event(note_event_type ev, int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  <= mnop_pkg::REQ_W'(ev);
      req_tvalid <= 1'b1;
      do @(posedge clock); while (req_tready !== 1'b1);
      @(negedge clock);
   endtask

   task automatic play_note(mnop_pkg::time_type t, mnop_pkg::key_type k,
                            logic [mnop_pkg::VEL_W-1:0] v);
      offer_event(make_event(t, k, v), idle_gap());
   endtask

   // Stops offering and waits until the unit has answered every event.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending != 0);
   endtask

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready)
         results_taken <= results_taken + 1;

   // Result side. Once, after a few hundred results, the receiver holds off
   // for a long stretch so the output register and the sequencer back up and
   // the unit stops taking events while the sender keeps offering.
   initial begin : result_pacing
      int gap;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         if (!hold_done && results_taken >= 300) begin
            rsp_tready <= 1'b0;
            repeat (400) @(negedge clock);
            hold_done = 1'b1;
         end else begin
            rsp_tready <= 1'b1;
            repeat (calm ? 1 : $urandom_range(1, 12)) @(negedge clock);
            if (!calm) begin
               gap = idle_gap();
               if (gap > 0) begin
                  rsp_tready <= 1'b0;
                  repeat (gap) @(negedge clock);
               end
            end
         end
      end
   end

   initial begin : stimulus
      mnop_pkg::key_type  key_a;
      mnop_pkg::key_type  key_b;
      mnop_pkg::key_type  note_key;
      mnop_pkg::key_type  key_pool[8];
      mnop_pkg::key_type  open_keys[$];
      mnop_pkg::time_type tick;
      note_event_type     ev;
      int                 on_pct;
      int                 pick;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part. The all-ones key has every key field at its maximum.
      key_a = mnop_pkg::key_type'($urandom());
      key_b = key_a ^ mnop_pkg::key_type'(1);
      // A note-off on an empty table has nothing to match.
      play_note(32'h0, '1, '0);
      // Two notes on the same key: the oldest one must be closed first.
      play_note(32'h0, '0, 7'd1);
      play_note(32'hFFFF_FFFF, '1, 7'd127);
      play_note(32'd5, '1, 7'd64);
      // End equal to start and end before start both give invalid timing,
      // and the note is still removed.
      play_note(32'hFFFF_FFFF, '1, '0);
      play_note(32'd4, '1, '0);
      // Largest possible duration, then the same key again finds nothing.
      play_note(32'hFFFF_FFFF, '0, '0);
      play_note(32'd1, '0, '0);
      // Closing the older of two notes moves the younger one down a place.
      play_note(32'd100, key_a, 7'($urandom_range(1, 127)));
      play_note(32'd200, key_b, 7'($urandom_range(1, 127)));
      // Differs only in the time mode bit, so it must not match.
      play_note(32'd250, key_a ^ (mnop_pkg::key_type'(1) << 25), '0);
      play_note(32'd150, key_a, '0);
      play_note(32'd300, key_b, '0);
      // Shortest valid duration.
      play_note(32'd1000, key_a, 7'($urandom_range(1, 127)));
      play_note(32'd1001, key_a, '0);
      play_note(32'd7, '0, 7'd127);
      play_note(32'd7, '0, '0);
      drain_results();

      // Random part, in phases. Most events are well-formed: note-ons on a
      // small pool of keys (so duplicates stack up) or on fresh keys, and
      // note-offs for keys that are open. The share of note-ons sets where
      // the table sits; the first phase fills it past full. A few events are
      // fully random noise.
      tick = $urandom();
      for (int phase = 0; phase < 12; phase++) begin
         if (phase == 0) begin
            on_pct = 95;
         end else begin
            case ($urandom_range(0, 3))
               0: on_pct = 30;
               1: on_pct = 50;
               2: on_pct = 70;
               default: on_pct = 95;
            endcase
         end
         calm = (phase == 3 || phase == 8);
         // Sometimes jump the clock just below its wrap, so durations that
         // straddle the wrap show up as invalid timing.
         case ($urandom_range(0, 2))
            0: tick = $urandom();
            1: tick = 32'hFFFF_FF00 | 32'($urandom_range(0, 255));
            default: ;
         endcase
         foreach (key_pool[i])
            key_pool[i] = mnop_pkg::key_type'($urandom());

         for (int n = 0; n < 152; n++) begin
            if ($urandom_range(0, 3) != 0)
               tick = tick + 32'($urandom_range(1, 400));
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
               ev = make_event($urandom(), mnop_pkg::key_type'($urandom()),
                               $urandom_range(0, 1) ? 7'd0 : 7'($urandom_range(1, 127)));
            end else if (open_keys.size() == 0 || $urandom_range(0, 99) < on_pct) begin
               note_key = $urandom_range(0, 1) ? key_pool[$urandom_range(0, 7)]
                                               : mnop_pkg::key_type'($urandom());
               ev = make_event(tick, note_key, 7'($urandom_range(1, 127)));
               if (open_keys.size() < mnop_pkg::OPEN_NOTES)
                  open_keys.push_back(note_key);
            end else begin
               pick = $urandom_range(0, open_keys.size() - 1);
               note_key = open_keys[pick];
               open_keys.delete(pick);
               ev = make_event(tick, note_key, '0);
               // Now and then the note-off carries an earlier time.
               if ($urandom_range(0, 9) == 0)
                  ev.tick_time = tick - 32'($urandom_range(0, 3000));
            end
            offer_event(ev, calm ? 0 : idle_gap());
         end
         drain_results();
      end
      calm = 1'b0;

      // Let any stray result show up before the verdict.
      repeat (20) @(negedge clock);
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
